[src/bsc_pkg.sv]
// Shared constants, codes and controller/datapath interface types for the safety checker.
package bsc_pkg;

	localparam int MAX_PROCESSES = 16;
	localparam int MAX_RESOURCES = 8;
	localparam int UNIT_WIDTH    = 16;

	// Index and count widths
	localparam int PROC_W  = $clog2(MAX_PROCESSES);
	localparam int RES_W   = $clog2(MAX_RESOURCES);
	localparam int PCNT_W  = $clog2(MAX_PROCESSES + 1);
	localparam int RCNT_W  = $clog2(MAX_RESOURCES + 1);
	localparam int ADDR_W  = PROC_W + RES_W;
	localparam int DEPTH   = MAX_PROCESSES * MAX_RESOURCES;
	// Work amount holds the free amount plus every allocation
	localparam int WORK_W  = UNIT_WIDTH + PCNT_W;

	// Fixed field widths of the stream payloads
	localparam int OP_W      = 2;
	localparam int PIDX_W    = 4;
	localparam int RIDX_W    = 3;
	localparam int FIELD_U_W = 16;
	localparam int POS_W     = 4;

	// Input tdata layout, lowest bit first
	localparam int IN_PIDX_LO  = 0;
	localparam int IN_RIDX_LO  = IN_PIDX_LO + PIDX_W;
	localparam int IN_CLAIM_LO = IN_RIDX_LO + RIDX_W;
	localparam int IN_HELD_LO  = IN_CLAIM_LO + FIELD_U_W;
	localparam int IN_FREE_LO  = IN_HELD_LO + FIELD_U_W;
	localparam int IN_BITS     = IN_FREE_LO + FIELD_U_W;
	localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS    = PIDX_W + POS_W;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	// Configuration port
	localparam int CFG_ADDR_W = 1;
	localparam int CFG_DATA_W = 5;
	localparam int PCOUNT_W   = 5;
	localparam int RCOUNT_W   = 4;
	localparam logic [CFG_ADDR_W-1:0] CFG_PROCESS_COUNT  = 1'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_RESOURCE_COUNT = 1'd1;

	// Operation codes carried in tuser
	localparam logic [OP_W-1:0] OP_LOAD_PROC = 2'd0;
	localparam logic [OP_W-1:0] OP_LOAD_FREE = 2'd1;
	localparam logic [OP_W-1:0] OP_CHECK     = 2'd2;

	// Controller to datapath commands
	typedef struct packed {
		logic wr_entry;     // store claim and allocation of the input beat
		logic wr_free;      // store available amount of the input beat
		logic start;        // seed work vector, clear marks and counters
		logic r_clr;
		logic r_inc;
		logic p_clr;        // new pass: back to process 0, clear progress
		logic p_inc;
		logic add;          // work[r] += allocation[p][r]
		logic finish;       // mark process, record it in the sequence
		logic emit_clr;
		logic emit_inc;
		logic out_safe;     // load a sequence beat into the output register
		logic out_unsafe;   // load the single unsafe beat
	} bsc_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic fits;         // need of (p, r) within work[r]
		logic marked;       // process p already finished
		logic last_r;
		logic last_p;
		logic all_done;
		logic progress;
		logic last_emit;
		logic out_free;
	} bsc_stat_t;

endpackage

[src/bsc_ram.sv]
// Generic one-write, one-read RAM with registered read data.
module bsc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[src/bsc_ctrl.sv]
// Sequencer for loads, safety sweeps and result emission.
module bsc_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [bsc_pkg::OP_W-1:0]      in_op,
	output logic                          in_ready,
	input  bsc_pkg::bsc_stat_t            stat,
	output bsc_pkg::bsc_cmd_t             cmd
);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_START  = 4'd1;
	localparam logic [3:0] ST_PROC   = 4'd2;
	localparam logic [3:0] ST_FIT_A  = 4'd3;
	localparam logic [3:0] ST_FIT_B  = 4'd4;
	localparam logic [3:0] ST_ADD_A  = 4'd5;
	localparam logic [3:0] ST_ADD_B  = 4'd6;
	localparam logic [3:0] ST_NEXT   = 4'd7;
	localparam logic [3:0] ST_EMIT   = 4'd8;
	localparam logic [3:0] ST_UNSAFE = 4'd9;

	localparam logic [bsc_pkg::OP_W-1:0] OP_LOAD_PROC_C = bsc_pkg::OP_LOAD_PROC;
	localparam logic [bsc_pkg::OP_W-1:0] OP_LOAD_FREE_C = bsc_pkg::OP_LOAD_FREE;
	localparam logic [bsc_pkg::OP_W-1:0] OP_CHECK_C     = bsc_pkg::OP_CHECK;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign in_ready = (state_q == ST_IDLE);

	// Next state and command decode
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (in_op)
						OP_LOAD_PROC_C: cmd.wr_entry = 1'b1;
						OP_LOAD_FREE_C: cmd.wr_free  = 1'b1;
						OP_CHECK_C:     state_d      = ST_START;
						default:        state_d      = ST_IDLE;
					endcase
				end
			end
			ST_START: begin
				cmd.start = 1'b1;
				state_d   = ST_PROC;
			end
			ST_PROC: begin
				cmd.r_clr = 1'b1;
				state_d   = stat.marked ? ST_NEXT : ST_FIT_A;
			end
			ST_FIT_A: begin
				state_d = ST_FIT_B;
			end
			ST_FIT_B: begin
				if (!stat.fits) begin
					state_d = ST_NEXT;
				end else if (stat.last_r) begin
					cmd.r_clr = 1'b1;
					state_d   = ST_ADD_A;
				end else begin
					cmd.r_inc = 1'b1;
					state_d   = ST_FIT_A;
				end
			end
			ST_ADD_A: begin
				state_d = ST_ADD_B;
			end
			ST_ADD_B: begin
				cmd.add = 1'b1;
				if (stat.last_r) begin
					cmd.finish = 1'b1;
					state_d    = ST_NEXT;
				end else begin
					cmd.r_inc = 1'b1;
					state_d   = ST_ADD_A;
				end
			end
			ST_NEXT: begin
				if (!stat.last_p) begin
					cmd.p_inc = 1'b1;
					state_d   = ST_PROC;
				end else if (stat.all_done) begin
					cmd.emit_clr = 1'b1;
					state_d      = ST_EMIT;
				end else if (!stat.progress) begin
					state_d = ST_UNSAFE;
				end else begin
					cmd.p_clr = 1'b1;
					state_d   = ST_PROC;
				end
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.out_safe = 1'b1;
					if (stat.last_emit) begin
						state_d = ST_IDLE;
					end else begin
						cmd.emit_inc = 1'b1;
					end
				end
			end
			ST_UNSAFE: begin
				if (stat.out_free) begin
					cmd.out_unsafe = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[src/bsc_dp.sv]
// Datapath: stores, work vector, sweep counters, sequence record and output register.
module bsc_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  bsc_pkg::bsc_cmd_t                   cmd,
	output bsc_pkg::bsc_stat_t                  stat,
	input  logic                                cfg_we,
	input  logic [bsc_pkg::CFG_ADDR_W-1:0]      cfg_addr,
	input  logic [bsc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	input  logic [bsc_pkg::PIDX_W-1:0]          in_pidx,
	input  logic [bsc_pkg::RIDX_W-1:0]          in_ridx,
	input  logic [bsc_pkg::FIELD_U_W-1:0]       in_claim,
	input  logic [bsc_pkg::FIELD_U_W-1:0]       in_held,
	input  logic [bsc_pkg::FIELD_U_W-1:0]       in_free,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [bsc_pkg::PIDX_W-1:0]          out_pid,
	output logic [bsc_pkg::POS_W-1:0]           out_pos,
	output logic                                out_safe,
	output logic                                out_last
);

	localparam int PROC_W = bsc_pkg::PROC_W;
	localparam int RES_W  = bsc_pkg::RES_W;
	localparam int PCNT_W = bsc_pkg::PCNT_W;
	localparam int RCNT_W = bsc_pkg::RCNT_W;
	localparam int UNIT_W = bsc_pkg::UNIT_WIDTH;
	localparam int WORK_W = bsc_pkg::WORK_W;
	localparam int NPROC  = bsc_pkg::MAX_PROCESSES;
	localparam int NRES   = bsc_pkg::MAX_RESOURCES;

	logic [bsc_pkg::PCOUNT_W-1:0] pcount_q;
	logic [bsc_pkg::RCOUNT_W-1:0] rcount_q;
	logic [PCNT_W-1:0]            np;
	logic [RCNT_W-1:0]            nr;

	logic [UNIT_W-1:0]  free_q  [NRES];
	logic [WORK_W-1:0]  work_q  [NRES];
	logic [NPROC-1:0]   mark_q;
	logic [PROC_W-1:0]  order_q [NPROC];

	logic [PROC_W-1:0]  p_q;
	logic [RES_W-1:0]   r_q;
	logic [PCNT_W-1:0]  done_q;
	logic               progress_q;
	logic [PROC_W-1:0]  emit_q;

	logic [UNIT_W-1:0]  claim_rd;
	logic [UNIT_W-1:0]  held_rd;
	logic [UNIT_W-1:0]  need;
	logic [bsc_pkg::ADDR_W-1:0] waddr;
	logic [bsc_pkg::ADDR_W-1:0] raddr;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcount_q <= bsc_pkg::PCOUNT_W'(1);
			rcount_q <= bsc_pkg::RCOUNT_W'(1);
		end else if (cfg_we) begin
			case (cfg_addr)
				bsc_pkg::CFG_PROCESS_COUNT:  pcount_q <= cfg_wdata[bsc_pkg::PCOUNT_W-1:0];
				bsc_pkg::CFG_RESOURCE_COUNT: rcount_q <= cfg_wdata[bsc_pkg::RCOUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp counts: zero acts as one, above the maximum acts as the maximum
	always_comb begin
		if (pcount_q == '0) begin
			np = PCNT_W'(1);
		end else if (32'(pcount_q) > NPROC) begin
			np = PCNT_W'(NPROC);
		end else begin
			np = PCNT_W'(pcount_q);
		end
		if (rcount_q == '0) begin
			nr = RCNT_W'(1);
		end else if (32'(rcount_q) > NRES) begin
			nr = RCNT_W'(NRES);
		end else begin
			nr = RCNT_W'(rcount_q);
		end
	end

	// Claim and allocation stores, addressed by process and resource
	assign waddr = {in_pidx[PROC_W-1:0], in_ridx[RES_W-1:0]};
	assign raddr = {p_q, r_q};

	bsc_ram #(.WIDTH(UNIT_W), .DEPTH(bsc_pkg::DEPTH)) u_claim_ram (
		.clk   (clk),
		.we    (cmd.wr_entry),
		.waddr (waddr),
		.wdata (in_claim[UNIT_W-1:0]),
		.raddr (raddr),
		.rdata (claim_rd)
	);

	bsc_ram #(.WIDTH(UNIT_W), .DEPTH(bsc_pkg::DEPTH)) u_held_ram (
		.clk   (clk),
		.we    (cmd.wr_entry),
		.waddr (waddr),
		.wdata (in_held[UNIT_W-1:0]),
		.raddr (raddr),
		.rdata (held_rd)
	);

	// Available amounts
	always_ff @(posedge clk) begin
		if (cmd.wr_free) begin
			free_q[in_ridx[RES_W-1:0]] <= in_free[UNIT_W-1:0];
		end
	end

	// Saturated need against the work amount of the current resource
	assign need = (claim_rd > held_rd) ? (claim_rd - held_rd) : '0;

	// Work vector: seed from available amounts, grow by finished allocations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NRES; i++) begin
				work_q[i] <= '0;
			end
		end else if (cmd.start) begin
			for (int i = 0; i < NRES; i++) begin
				work_q[i] <= WORK_W'(free_q[i]);
			end
		end else if (cmd.add) begin
			work_q[r_q] <= work_q[r_q] + WORK_W'(held_rd);
		end
	end

	// Sweep counters, finish marks and progress
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q        <= '0;
			r_q        <= '0;
			done_q     <= '0;
			progress_q <= 1'b0;
			mark_q     <= '0;
			emit_q     <= '0;
		end else begin
			if (cmd.start) begin
				p_q        <= '0;
				done_q     <= '0;
				progress_q <= 1'b0;
				mark_q     <= '0;
			end
			if (cmd.p_clr) begin
				p_q        <= '0;
				progress_q <= 1'b0;
			end
			if (cmd.p_inc) begin
				p_q <= p_q + PROC_W'(1);
			end
			if (cmd.r_clr) begin
				r_q <= '0;
			end
			if (cmd.r_inc) begin
				r_q <= r_q + RES_W'(1);
			end
			if (cmd.finish) begin
				mark_q[p_q] <= 1'b1;
				done_q      <= done_q + PCNT_W'(1);
				progress_q  <= 1'b1;
			end
			if (cmd.emit_clr) begin
				emit_q <= '0;
			end
			if (cmd.emit_inc) begin
				emit_q <= emit_q + PROC_W'(1);
			end
		end
	end

	// Record the finishing order
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			order_q[done_q[PROC_W-1:0]] <= p_q;
		end
	end

	// Output register: load a beat, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_safe || cmd.out_unsafe) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_safe) begin
			out_pid  <= bsc_pkg::PIDX_W'(order_q[emit_q]);
			out_pos  <= bsc_pkg::POS_W'(emit_q);
			out_safe <= 1'b1;
			out_last <= stat.last_emit;
		end else if (cmd.out_unsafe) begin
			out_pid  <= '0;
			out_pos  <= '0;
			out_safe <= 1'b0;
			out_last <= 1'b1;
		end
	end

	// Status to the controller
	always_comb begin
		stat.fits      = WORK_W'(need) <= work_q[r_q];
		stat.marked    = mark_q[p_q];
		stat.last_r    = (RCNT_W'(r_q) + RCNT_W'(1)) == nr;
		stat.last_p    = (PCNT_W'(p_q) + PCNT_W'(1)) == np;
		stat.all_done  = done_q == np;
		stat.progress  = progress_q;
		stat.last_emit = (PCNT_W'(emit_q) + PCNT_W'(1)) == np;
		stat.out_free  = !out_valid || out_ready;
	end

endmodule

[src/bankers_safety_check.sv]
// Top level of the banker's algorithm safety checker.
//
//  Channel   Signals                         Carries
//  s_axis    s_tvalid s_tready s_tuser s_tdata  load entry, load available, run check
//  m_axis    m_tvalid m_tready m_tuser m_tlast m_tdata  safe sequence or one unsafe beat
//  cfg       cfg_we cfg_addr cfg_wdata       process_count (0), resource_count (1)
//
// A load beat is stored as it is taken; the next beat can be taken in the following cycle.
// A check seeds the work vector after its beat, then per pass and per unmarked process
// reads claim and allocation one resource at a time to compare need with work, then again
// to add the allocation when the process fits, bound by the single read port of the
// claim/allocation RAMs; at most np passes.
// Results leave one beat per cycle while m_tready takes them; the input is held off
// until the last one is in the output register, which a stalled m_tready holds.
// Reset is immediate, no clearing pass.
module bankers_safety_check (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [bsc_pkg::OP_W-1:0]           s_tuser,   // operation
	input  logic [bsc_pkg::IN_TDATA_W-1:0]     s_tdata,   // process_index, resource_index,
	                                                      // max_claim, held_units, free_units
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic                               m_tuser,   // safe
	output logic                               m_tlast,   // last
	output logic [bsc_pkg::OUT_TDATA_W-1:0]    m_tdata,   // process_id, position
	input  logic                               cfg_we,
	input  logic [bsc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [bsc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	bsc_pkg::bsc_cmd_t  cmd;
	bsc_pkg::bsc_stat_t stat;
	logic [bsc_pkg::PIDX_W-1:0] out_pid;
	logic [bsc_pkg::POS_W-1:0]  out_pos;

	bsc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_op    (s_tuser),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	bsc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.in_pidx   (s_tdata[bsc_pkg::IN_RIDX_LO-1:bsc_pkg::IN_PIDX_LO]),
		.in_ridx   (s_tdata[bsc_pkg::IN_CLAIM_LO-1:bsc_pkg::IN_RIDX_LO]),
		.in_claim  (s_tdata[bsc_pkg::IN_HELD_LO-1:bsc_pkg::IN_CLAIM_LO]),
		.in_held   (s_tdata[bsc_pkg::IN_FREE_LO-1:bsc_pkg::IN_HELD_LO]),
		.in_free   (s_tdata[bsc_pkg::IN_BITS-1:bsc_pkg::IN_FREE_LO]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_pid   (out_pid),
		.out_pos   (out_pos),
		.out_safe  (m_tuser),
		.out_last  (m_tlast)
	);

	// Pack the result beat, zero pad to whole bytes
	assign m_tdata = bsc_pkg::OUT_TDATA_W'({out_pos, out_pid});

endmodule

[verif/bankers_safety_check_tb.sv]
// Testbench for the banker's safety checker: directed and random traffic against a predictor.
`timescale 1ns / 100ps

module bankers_safety_check_tb;

	localparam logic [bsc_pkg::OP_W-1:0] OP_RESERVED = 2'd3;
	localparam int SETTLE_CYCLES = 20;
	localparam int STUCK_LIMIT   = 60000;
	localparam int HOLD_LEN      = 600;
	localparam int UNIT_MAX      = 65535;

	// Input tdata fields, lowest bit last in the list
	typedef struct packed {
		logic [bsc_pkg::IN_TDATA_W-bsc_pkg::IN_BITS-1:0] pad;
		logic [bsc_pkg::FIELD_U_W-1:0]                   free_units;
		logic [bsc_pkg::FIELD_U_W-1:0]                   held_units;
		logic [bsc_pkg::FIELD_U_W-1:0]                   max_claim;
		logic [bsc_pkg::RIDX_W-1:0]                      res_idx;
		logic [bsc_pkg::PIDX_W-1:0]                      proc_idx;
	} load_beat_t;

	typedef struct packed {
		logic [bsc_pkg::PIDX_W-1:0] proc_id;
		logic [bsc_pkg::POS_W-1:0]  position;
		logic                       safe;
		logic                       last;
	} seq_beat_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             s_tvalid = 1'b0;
	logic                             s_tready;
	logic [bsc_pkg::OP_W-1:0]         s_tuser = '0;   // operation
	logic [bsc_pkg::IN_TDATA_W-1:0]   s_tdata = '0;   // process_index, resource_index,
	                                                  // max_claim, held_units, free_units
	logic                             m_tvalid;
	logic                             m_tready = 1'b0;
	logic                             m_tuser;        // safe
	logic                             m_tlast;        // last
	logic [bsc_pkg::OUT_TDATA_W-1:0]  m_tdata;        // process_id, position
	logic                             cfg_we = 1'b0;
	logic [bsc_pkg::CFG_ADDR_W-1:0]   cfg_addr = '0;
	logic [bsc_pkg::CFG_DATA_W-1:0]   cfg_wdata = '0;

	// Predictor state
	logic [bsc_pkg::FIELD_U_W-1:0] claim_mem [bsc_pkg::DEPTH];
	logic [bsc_pkg::FIELD_U_W-1:0] held_mem [bsc_pkg::DEPTH];
	logic [bsc_pkg::FIELD_U_W-1:0] free_mem [bsc_pkg::MAX_RESOURCES];
	bit                            entry_loaded [bsc_pkg::DEPTH];
	bit                            free_loaded [bsc_pkg::MAX_RESOURCES];
	logic [bsc_pkg::PCOUNT_W-1:0]  proc_cnt_q = 5'd1;
	logic [bsc_pkg::RCOUNT_W-1:0]  res_cnt_q = 4'd1;
	seq_beat_t                     seq_q [$];

	int errors = 0;
	int items_sent = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int stall_ticket = 0;

	bankers_safety_check dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	always #1 clk = ~clk;

	// Drive the receiver: random idling, or a long hold-off on request
	always @(negedge clk) begin : sink
		int stall_taken;
		int stall_left;
		if (stall_ticket != stall_taken) begin
			stall_taken = stall_ticket;
			stall_left  = HOLD_LEN;
		end
		if (stall_left > 0) begin
			stall_left = stall_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Compare each result beat with the oldest expected one
	always @(posedge clk) begin : seq_check
		seq_beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (seq_q.size() == 0) begin
				$error("result beat with nothing expected: process_id %0d position %0d",
					m_tdata[3:0], m_tdata[7:4]);
				errors++;
			end else begin
				want = seq_q.pop_front();
				if (m_tdata[3:0] !== want.proc_id) begin
					$error("process_id: expected %0d, got %0d", want.proc_id, m_tdata[3:0]);
					errors++;
				end
				if (m_tdata[7:4] !== want.position) begin
					$error("position: expected %0d, got %0d", want.position, m_tdata[7:4]);
					errors++;
				end
				if (m_tuser !== want.safe) begin
					$error("safe: expected %0d, got %0d", want.safe, m_tuser);
					errors++;
				end
				if (m_tlast !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, m_tlast);
					errors++;
				end
			end
		end
	end

	// End the run when no beat moves for too long
	always @(posedge clk) begin : watchdog
		int stuck_cycles;
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stuck_cycles = 0;
		end else if (stuck_cycles >= STUCK_LIMIT) begin
			$display("watchdog: no beat accepted for %0d cycles", stuck_cycles);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			stuck_cycles = stuck_cycles + 1;
		end
	end

	function automatic int eff_count(int value, int top);
		if (value == 0)
			return 1;
		if (value > top)
			return top;
		return value;
	endfunction

	// Run the safety test on the predictor state and queue the expected beats
	function automatic void predict_check();
		logic [bsc_pkg::WORK_W-1:0]    work [bsc_pkg::MAX_RESOURCES];
		bit                            marked [bsc_pkg::MAX_PROCESSES];
		logic [bsc_pkg::PIDX_W-1:0]    order [bsc_pkg::MAX_PROCESSES];
		logic [bsc_pkg::FIELD_U_W-1:0] need;
		seq_beat_t                     beat_exp;
		int np, nr, finished, p, r, idx;
		bit progress, fit;
		np = eff_count(proc_cnt_q, bsc_pkg::MAX_PROCESSES);
		nr = eff_count(res_cnt_q, bsc_pkg::MAX_RESOURCES);
		for (r = 0; r < bsc_pkg::MAX_RESOURCES; r++)
			work[r] = bsc_pkg::WORK_W'(free_mem[r]);
		for (p = 0; p < bsc_pkg::MAX_PROCESSES; p++)
			marked[p] = 1'b0;
		finished = 0;
		do begin
			progress = 1'b0;
			for (p = 0; p < np; p++) begin
				if (!marked[p]) begin
					fit = 1'b1;
					for (r = 0; r < nr; r++) begin
						idx  = p * bsc_pkg::MAX_RESOURCES + r;
						need = (claim_mem[idx] > held_mem[idx]) ?
							claim_mem[idx] - held_mem[idx] : '0;
						if (need > work[r])
							fit = 1'b0;
					end
					if (fit) begin
						for (r = 0; r < nr; r++)
							work[r] += held_mem[p * bsc_pkg::MAX_RESOURCES + r];
						marked[p] = 1'b1;
						order[finished] = bsc_pkg::PIDX_W'(p);
						finished++;
						progress = 1'b1;
					end
				end
			end
		end while (progress && finished < np);
		if (finished < np) begin
			beat_exp = '{proc_id: '0, position: '0, safe: 1'b0, last: 1'b1};
			seq_q = {seq_q, beat_exp};
		end else begin
			for (p = 0; p < np; p++) begin
				beat_exp = '{proc_id: order[p], position: bsc_pkg::POS_W'(p), safe: 1'b1,
					last: (p == np - 1)};
				seq_q = {seq_q, beat_exp};
			end
		end
	endfunction

	// Update the predictor with one accepted input beat
	function automatic void apply_beat(logic [bsc_pkg::OP_W-1:0] op, load_beat_t beat);
		int idx;
		idx = beat.proc_idx * bsc_pkg::MAX_RESOURCES + beat.res_idx;
		case (op)
			bsc_pkg::OP_LOAD_PROC: begin
				claim_mem[idx]    = beat.max_claim;
				held_mem[idx]     = beat.held_units;
				entry_loaded[idx] = 1'b1;
			end
			bsc_pkg::OP_LOAD_FREE: begin
				free_mem[beat.res_idx]    = beat.free_units;
				free_loaded[beat.res_idx] = 1'b1;
			end
			bsc_pkg::OP_CHECK: predict_check();
			default: ;
		endcase
	endfunction

	function automatic load_beat_t pack_beat(int pi, int ri, int claim, int held, int free_amt);
		load_beat_t beat;
		beat.pad        = '0;
		beat.proc_idx   = bsc_pkg::PIDX_W'(pi);
		beat.res_idx    = bsc_pkg::RIDX_W'(ri);
		beat.max_claim  = bsc_pkg::FIELD_U_W'(claim);
		beat.held_units = bsc_pkg::FIELD_U_W'(held);
		beat.free_units = bsc_pkg::FIELD_U_W'(free_amt);
		return beat;
	endfunction

	// Offer one beat, with random idle cycles ahead of it, and hold it until taken
	task automatic send_beat(logic [bsc_pkg::OP_W-1:0] op, load_beat_t beat);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= beat;
		do @(posedge clk); while (!s_tready);
		apply_beat(op, beat);
		if (op != OP_RESERVED)
			items_sent++;
	endtask

	task automatic load_entry(int p, int r, int claim, int held);
		send_beat(bsc_pkg::OP_LOAD_PROC,
			pack_beat(p, r, claim, held, $urandom_range(UNIT_MAX)));
	endtask

	task automatic load_free(int r, int free_amt);
		send_beat(bsc_pkg::OP_LOAD_FREE, pack_beat($urandom_range(15), r,
			$urandom_range(UNIT_MAX), $urandom_range(UNIT_MAX), free_amt));
	endtask

	// Allocation up to scale; need up to scale, or zero by a claim at or below the allocation
	task automatic load_random_entry(int p, int r, int scale);
		int held, claim;
		held = $urandom_range(scale);
		if ($urandom_range(4) == 0)
			claim = $urandom_range(held);
		else
			claim = held + $urandom_range(scale);
		if (claim > UNIT_MAX)
			claim = UNIT_MAX;
		load_entry(p, r, claim, held);
	endtask

	// Load every entry the check will read, then send the check
	task automatic run_check();
		int p, r;
		for (r = 0; r < bsc_pkg::MAX_RESOURCES; r++)
			if (!free_loaded[r])
				load_free(r, $urandom_range(UNIT_MAX));
		for (p = 0; p < eff_count(proc_cnt_q, bsc_pkg::MAX_PROCESSES); p++)
			for (r = 0; r < eff_count(res_cnt_q, bsc_pkg::MAX_RESOURCES); r++)
				if (!entry_loaded[p * bsc_pkg::MAX_RESOURCES + r])
					load_random_entry(p, r, 15);
		send_beat(bsc_pkg::OP_CHECK, pack_beat($urandom_range(15), $urandom_range(7),
			$urandom_range(UNIT_MAX), $urandom_range(UNIT_MAX), $urandom_range(UNIT_MAX)));
	endtask

	// Drop valid, wait for every expected beat, then let the block settle
	task automatic wait_sequence_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (seq_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(logic [bsc_pkg::CFG_ADDR_W-1:0] addr,
		logic [bsc_pkg::CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= addr;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (addr == bsc_pkg::CFG_PROCESS_COUNT)
			proc_cnt_q = bsc_pkg::PCOUNT_W'(value);
		else
			res_cnt_q = bsc_pkg::RCOUNT_W'(value);
	endtask

	// One random case: noise, a repeated check, or new entries followed by a check
	task automatic random_case();
		int pick, scale, np, nr, nent, k, r, free_amt;
		np   = eff_count(proc_cnt_q, bsc_pkg::MAX_PROCESSES);
		nr   = eff_count(res_cnt_q, bsc_pkg::MAX_RESOURCES);
		pick = $urandom_range(99);
		case ($urandom_range(3))
			0: scale = 3;
			1: scale = 15;
			2: scale = 255;
			default: scale = UNIT_MAX;
		endcase
		if (pick < 15) begin
			case ($urandom_range(2))
				0: send_beat(bsc_pkg::OP_LOAD_PROC, pack_beat($urandom_range(15),
					$urandom_range(7), $urandom_range(UNIT_MAX), $urandom_range(UNIT_MAX),
					$urandom_range(UNIT_MAX)));
				1: send_beat(bsc_pkg::OP_LOAD_FREE, pack_beat($urandom_range(15),
					$urandom_range(7), $urandom_range(UNIT_MAX), $urandom_range(UNIT_MAX),
					$urandom_range(UNIT_MAX)));
				default: send_beat(OP_RESERVED, pack_beat($urandom_range(15),
					$urandom_range(7), $urandom_range(UNIT_MAX), $urandom_range(UNIT_MAX),
					$urandom_range(UNIT_MAX)));
			endcase
		end else if (pick < 25) begin
			run_check();
		end else begin
			nent = $urandom_range(1, (np * nr < 6) ? np * nr : 6);
			for (k = 0; k < nent; k++)
				load_random_entry($urandom_range(np - 1), $urandom_range(nr - 1), scale);
			if ($urandom_range(2) != 0) begin
				for (r = 0; r < nr; r++) begin
					free_amt = $urandom_range(2 * scale);
					load_free(r, (free_amt > UNIT_MAX) ? UNIT_MAX : free_amt);
				end
			end
			run_check();
		end
	endtask

	// Field extremes, every operation, saturated need, unsafe and multi-pass cases
	task automatic test_directed_cases();
		int r;
		load_free(0, 0);
		load_free(1, UNIT_MAX);
		load_free(2, 16'h5555);
		load_free(3, 16'hAAAA);
		for (r = 4; r < bsc_pkg::MAX_RESOURCES; r++)
			load_free(r, $urandom_range(UNIT_MAX));
		// need saturates to zero, so the lone process finishes in the first pass
		load_entry(0, 0, 0, UNIT_MAX);
		run_check();
		// full claim against nothing free
		load_entry(0, 0, UNIT_MAX, 0);
		run_check();
		send_beat(OP_RESERVED, pack_beat(15, 7, UNIT_MAX, UNIT_MAX, UNIT_MAX));
		// entry beyond the configured counts
		load_entry(15, 7, UNIT_MAX, UNIT_MAX);
		wait_sequence_drained();
		cfg_write(bsc_pkg::CFG_PROCESS_COUNT, 5'd2);
		// process 1 frees enough for process 0 on the second pass
		load_entry(0, 0, 4, 1);
		load_entry(1, 0, 3, 1);
		load_free(0, 2);
		run_check();
	endtask

	task automatic test_random_phase(logic [bsc_pkg::CFG_DATA_W-1:0] pcount,
		logic [bsc_pkg::CFG_DATA_W-1:0] rcount, int s_idle, int r_idle, int n_items);
		int start;
		wait_sequence_drained();
		cfg_write(bsc_pkg::CFG_PROCESS_COUNT, pcount);
		cfg_write(bsc_pkg::CFG_RESOURCE_COUNT, rcount);
		send_idle_pct = s_idle;
		recv_idle_pct = r_idle;
		start = items_sent;
		while (items_sent - start < n_items)
			random_case();
	endtask

	// Hold the receiver off while full sequences and loads keep coming
	task automatic test_output_backpressure();
		int p, r, k;
		wait_sequence_drained();
		cfg_write(bsc_pkg::CFG_PROCESS_COUNT, 5'd16);
		cfg_write(bsc_pkg::CFG_RESOURCE_COUNT, 5'd2);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (p = 0; p < bsc_pkg::MAX_PROCESSES; p++)
			for (r = 0; r < 2; r++) begin
				k = $urandom_range(UNIT_MAX);
				load_entry(p, r, $urandom_range(k), k);
			end
		stall_ticket++;
		for (k = 0; k < 3; k++) begin
			run_check();
			load_random_entry($urandom_range(15), $urandom_range(1), 3);
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_cases();
		test_random_phase(5'd5, 5'd3, 10, 79, 20);
		test_random_phase(5'd0, 5'd31, 79, 10, 20);
		test_random_phase(5'd31, 5'd16, 0, 0, 20);
		test_output_backpressure();

		wait_sequence_drained();
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

[bankers_safety_check.f]
src/bsc_pkg.sv
src/bsc_ram.sv
src/bsc_ctrl.sv
src/bsc_dp.sv
src/bankers_safety_check.sv
verif/bankers_safety_check_tb.sv
